### rtl/sre_pkg.sv
// Shared constants and types of the serpentine scan run-length encoder.
package sre_pkg;

    localparam int ROWS       = 16;
    localparam int COLS       = 16;
    localparam int PIXEL_BITS = 8;

    localparam int VALUE_W = 8;
    localparam int LEN_W   = 9;
    localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [VALUE_W-1:0] PIX_MASK =
        (PIXEL_BITS >= VALUE_W) ? {VALUE_W{1'b1}} : VALUE_W'((1 << PIXEL_BITS) - 1);
    localparam logic [LEN_W-1:0] COUNT_MAX = {LEN_W{1'b1}};
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);

    // One element offered to the run coder.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               last;
    } feed_t;

    // Access to the odd-row buffer.
    typedef struct packed {
        logic               wr_en;
        logic [COL_W-1:0]   wr_addr;
        logic [VALUE_W-1:0] wr_data;
        logic               rd_en;
        logic [COL_W-1:0]   rd_addr;
    } buf_req_t;

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_REPLAY = 2'b10
    } scan_state_t;

endpackage

### rtl/serpentine_scan_rle_encoder.sv
// Top level: frame position, serpentine replay sequencer, row buffer and run coder.
//
//  Channel  Direction  Content
//  s_axis   in         tdata[7:0] pixel
//  m_axis   out        tdata[7:0] run_value, tdata[16:8] run_length; tlast frame_end
//
// Pixels of even rows pass straight to the coder, one item per cycle while the coder is ready.
// Pixels of odd rows are written to the row buffer at one item per cycle; after
// the last pixel of an odd row the buffer is read back reversed, first one registered
// read, then one element a cycle while the coder takes them, with no input taken.
// The coder stalls while the output register is full and m_axis_tready is low; a
// frame whose last element opens a new run holds the final pair pending, and no input is taken until it is sent.
// Reset is synchronous, active low, and returns to the first pixel of a frame.
module serpentine_scan_rle_encoder
    import sre_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] run_value, [16:8] run_length
    output logic        m_axis_tlast    // frame_end
);

    scan_state_t        state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   k_reg, k_next;
    logic               data_valid_reg, data_valid_next;
    logic               odd_row, last_row, last_col;
    logic               in_fire, feed_fire, feed_ready;
    logic [VALUE_W-1:0] pixel, rd_data;
    feed_t              feed;
    buf_req_t           buf_req;
    logic [VALUE_W-1:0] run_value;
    logic [LEN_W-1:0]   run_length;

    assign pixel    = s_axis_tdata & PIX_MASK;
    assign odd_row  = row_reg[0];
    assign last_row = (row_reg == ROW_LAST);
    assign last_col = (col_reg == COL_LAST);

    assign s_axis_tready = (state_reg == ST_ACCEPT) && (odd_row || feed_ready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (state_reg == ST_REPLAY) begin
            feed.valid = data_valid_reg;
            feed.value = rd_data;
            feed.last  = last_row && (k_reg == '0);
        end else begin
            feed.valid = s_axis_tvalid && !odd_row;
            feed.value = pixel;
            feed.last  = last_row && last_col;
        end
    end

    assign feed_fire = feed.valid && feed_ready;

    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        k_next          = k_reg;
        data_valid_next = data_valid_reg;
        buf_req.wr_en   = in_fire && odd_row;
        buf_req.wr_addr = col_reg;
        buf_req.wr_data = pixel;
        buf_req.rd_en   = 1'b0;
        buf_req.rd_addr = k_reg;

        case (state_reg)
            ST_ACCEPT: begin
                if (in_fire) begin
                    if (!last_col) begin
                        col_next = col_reg + COL_W'(1);
                    end else begin
                        col_next = '0;
                        if (odd_row) begin
                            // Row complete in the buffer: replay it from the right.
                            state_next      = ST_REPLAY;
                            k_next          = COL_LAST;
                            data_valid_next = 1'b0;
                        end else begin
                            row_next = last_row ? '0 : row_reg + ROW_W'(1);
                        end
                    end
                end
            end
            ST_REPLAY: begin
                if (!data_valid_reg) begin
                    buf_req.rd_en   = 1'b1;
                    data_valid_next = 1'b1;
                end else if (feed_fire) begin
                    if (k_reg == '0) begin
                        state_next      = ST_ACCEPT;
                        data_valid_next = 1'b0;
                        row_next        = last_row ? '0 : row_reg + ROW_W'(1);
                    end else begin
                        // Fetch the next element while this one enters the coder.
                        buf_req.rd_en   = 1'b1;
                        buf_req.rd_addr = k_reg - COL_W'(1);
                        k_next          = k_reg - COL_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_ACCEPT;
            col_reg        <= '0;
            row_reg        <= '0;
            k_reg          <= '0;
            data_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            k_reg          <= k_next;
            data_valid_reg <= data_valid_next;
        end
    end

    sre_row_buf u_row_buf (
        .aclk    (aclk),
        .req     (buf_req),
        .rd_data (rd_data)
    );

    sre_coder u_coder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .feed       (feed),
        .feed_ready (feed_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (run_value),
        .out_length (run_length),
        .out_end    (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, run_length, run_value};

endmodule

### rtl/sre_row_buf.sv
// Odd-row buffer: one synchronous memory with a registered read port.
module sre_row_buf
    import sre_pkg::*;
(
    input  logic               aclk,
    input  buf_req_t           req,
    output logic [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem [COLS];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/sre_coder.sv
// Run-length coder with an output register and room for one pending final run.
module sre_coder
    import sre_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  feed_t              feed,
    output logic               feed_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_value,
    output logic [LEN_W-1:0]   out_length,
    output logic               out_end
);

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [LEN_W-1:0]   out_length_reg, out_length_next;
    logic               out_end_reg, out_end_next;
    logic [VALUE_W-1:0] open_value_reg, open_value_next;
    logic [LEN_W-1:0]   open_count_reg, open_count_next;
    logic               pend_reg, pend_next;
    logic               out_free;
    logic               close_old;
    logic [VALUE_W-1:0] run_value;
    logic [LEN_W-1:0]   run_count;

    assign out_free   = !out_valid_reg || out_ready;
    assign feed_ready = out_free && !pend_reg;

    always_comb begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_length_next = out_length_reg;
        out_end_next    = out_end_reg;
        open_value_next = open_value_reg;
        open_count_next = open_count_reg;
        pend_next       = pend_reg;
        close_old       = 1'b0;
        run_value       = feed.value;
        run_count       = LEN_W'(1);

        if (open_count_reg != '0 && feed.value == open_value_reg) begin
            run_value = open_value_reg;
            run_count = (open_count_reg == COUNT_MAX) ? COUNT_MAX
                                                      : open_count_reg + LEN_W'(1);
        end else if (open_count_reg != '0) begin
            close_old = 1'b1;
        end

        if (pend_reg && out_free) begin
            // The final run held back behind the run it closed.
            out_valid_next  = 1'b1;
            out_value_next  = open_value_reg;
            out_length_next = open_count_reg;
            out_end_next    = 1'b1;
            open_value_next = '0;
            open_count_next = '0;
            pend_next       = 1'b0;
        end else if (feed.valid && feed_ready) begin
            if (close_old) begin
                out_valid_next  = 1'b1;
                out_value_next  = open_value_reg;
                out_length_next = open_count_reg;
                out_end_next    = 1'b0;
                open_value_next = run_value;
                open_count_next = run_count;
                pend_next       = feed.last;
            end else if (feed.last) begin
                out_valid_next  = 1'b1;
                out_value_next  = run_value;
                out_length_next = run_count;
                out_end_next    = 1'b1;
                open_value_next = '0;
                open_count_next = '0;
            end else begin
                open_value_next = run_value;
                open_count_next = run_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            open_value_reg <= '0;
            open_count_reg <= '0;
            pend_reg       <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            open_value_reg <= open_value_next;
            open_count_reg <= open_count_next;
            pend_reg       <= pend_next;
        end
        out_value_reg  <= out_value_next;
        out_length_reg <= out_length_next;
        out_end_reg    <= out_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_length = out_length_reg;
    assign out_end    = out_end_reg;

endmodule

### tb/testbench.sv
// Self-checking testbench for the serpentine scan run-length encoder.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sre_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int FRAME_PIXELS = ROWS * COLS;
    localparam int PHASE_LEN    = FRAME_PIXELS / 3;
    localparam int HOLD_AT      = 2 * PHASE_LEN + COLS;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 3 * COLS + 8;
    localparam int REPORT_LIMIT = 50;

    // Forcing of the final element of a frame.
    typedef enum int {
        TAIL_FREE,
        TAIL_SAME,
        TAIL_DIFFERENT
    } tail_kind_t;

    // Content style of a frame.
    typedef enum int {
        STYLE_MIXED,
        STYLE_FLAT,
        STYLE_NOISY
    } frame_style_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [LEN_W-1:0]   length;
        logic               frame_end;
    } run_t;

    class rle_scoreboard;
        logic [VALUE_W-1:0] row_buf [COLS];
        logic [VALUE_W-1:0] run_val;
        logic [LEN_W-1:0]   run_len;
        int unsigned        row;
        int unsigned        col;
        run_t               runs_due[$];
        int unsigned        fails;

        function new();
            run_val = '0;
            run_len = '0;
            row     = 0;
            col     = 0;
            fails   = 0;
        endfunction

        function void close_run(bit is_end);
            run_t r;
            r.value     = run_val;
            r.length    = run_len;
            r.frame_end = is_end;
            runs_due.push_back(r);
        endfunction

        // Passes one element, in serpentine order, through the run coder.
        function void code_element(logic [VALUE_W-1:0] v, bit is_last);
            if (run_len == '0) begin
                run_val = v;
                run_len = LEN_W'(1);
            end else if (v == run_val) begin
                if (run_len != COUNT_MAX)
                    run_len = run_len + LEN_W'(1);
            end else begin
                close_run(1'b0);
                run_val = v;
                run_len = LEN_W'(1);
            end
            if (is_last) begin
                close_run(1'b1);
                run_val = '0;
                run_len = '0;
            end
        endfunction

        function void note_pixel(logic [7:0] raw);
            logic [VALUE_W-1:0] v;
            bit                 last_row;
            bit                 last_col;
            v        = raw & PIX_MASK;
            last_row = (row >= ROWS - 1);
            last_col = (col >= COLS - 1);
            if (row % 2 == 0) begin
                code_element(v, last_row && last_col);
            end else begin
                row_buf[col] = v;
                if (last_col) begin
                    for (int k = COLS - 1; k >= 0; k--)
                        code_element(row_buf[k], last_row && k == 0);
                end
            end
            if (last_col) begin
                col = 0;
                if (last_row) begin
                    row     = 0;
                    run_val = '0;
                    run_len = '0;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
        endfunction

        function void flag(string field, int unsigned want, int unsigned got);
            fails++;
            if (fails <= REPORT_LIMIT)
                $error("%s: expected %0d, actual %0d", field, want, got);
        endfunction

        function void check_run(logic [VALUE_W-1:0] value, logic [LEN_W-1:0] length,
                                logic frame_end);
            run_t want;
            if (runs_due.size() == 0) begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $error("run with no expectation: value %0d length %0d end %0d",
                           value, length, frame_end);
            end else begin
                want = runs_due.pop_front();
                if (value !== want.value)
                    flag("run_value", want.value, value);
                if (length !== want.length)
                    flag("run_length", want.length, length);
                if (frame_end !== want.frame_end)
                    flag("frame_end", want.frame_end, frame_end);
            end
        endfunction

        function int pending();
            return runs_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    rle_scoreboard sb = new();

    int  src_idle_pct  = 0;
    int  sink_idle_pct = 0;
    bit  hold_request  = 0;

    logic [7:0] frame_pix [ROWS][COLS];

    serpentine_scan_rle_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    // Both channels are observed at the rising edge, where the values driven at the
    // previous falling edge are settled.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_run(m_axis_tdata[7:0], m_axis_tdata[16:8], m_axis_tlast);
        end
    end

    // Receiver: random stalls, and one long hold-off on request.
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_pixel(input logic [7:0] p);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do
            @(posedge aclk);
        while (!s_axis_tready);
    endtask

    function automatic logic [7:0] pick_value();
        logic [7:0] palette [4] = '{8'h00, 8'hFF, 8'h3C, 8'hC3};
        case ($urandom_range(3))
            0:       return palette[$urandom_range(3)];
            1:       return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Fills a frame in raster order; runs carry on from one element to the next.
    task automatic build_frame(input frame_style_t style, input tail_kind_t tail);
        logic [7:0] cur;
        int         change_pct;
        cur = pick_value();
        case (style)
            STYLE_FLAT:  change_pct = 0;
            STYLE_NOISY: change_pct = 85;
            default:     change_pct = 30;
        endcase
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                if ($urandom_range(99) < change_pct)
                    cur = pick_value();
                frame_pix[r][c] = cur;
            end
        end
        // The last element of the frame in serpentine order is the first of the last row.
        case (tail)
            TAIL_SAME:      frame_pix[ROWS-1][0] = frame_pix[ROWS-1][1];
            TAIL_DIFFERENT: frame_pix[ROWS-1][0] = ~frame_pix[ROWS-1][1];
            default:        ;
        endcase
    endtask

    initial begin
        logic [7:0] opening [24] = '{
            8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80,
            8'h7F, 8'hFE, 8'h55, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA,
            8'h0F, 8'hF0, 8'hF0, 8'h33, 8'hCC, 8'hCC, 8'hCC, 8'hFF
        };
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        build_frame(STYLE_MIXED, TAIL_DIFFERENT);
        // Directed opening: field extremes and short runs.
        for (int i = 0; i < 24; i++)
            frame_pix[i / COLS][i % COLS] = opening[i];

        // The idling pattern changes in thirds of the frame, and the receiver holds
        // off once in the last third while the sender keeps offering items.
        for (int i = 0; i < FRAME_PIXELS; i++) begin
            if (i < PHASE_LEN) begin
                src_idle_pct  = 17;
                sink_idle_pct = 76;
            end else if (i < 2 * PHASE_LEN) begin
                src_idle_pct  = 76;
                sink_idle_pct = 17;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (i == HOLD_AT)
                hold_request = 1;
            send_pixel(frame_pix[i / COLS][i % COLS]);
        end

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### files.f
rtl/sre_pkg.sv
rtl/sre_row_buf.sv
rtl/sre_coder.sv
rtl/serpentine_scan_rle_encoder.sv
tb/testbench.sv
